// ===== rtl/ctsc_pkg.sv =====
`timescale 1ns / 1ps

package ctsc_pkg;

    // Field widths fixed by the interface
    localparam int X_W       = 10;
    localparam int ROW_W     = 7;
    localparam int OUT_ROW_W = 6;

    // Defaults for the top-level parameters
    localparam int ROWS_DEF    = 64;
    localparam int COLUMNS_DEF = 1024;

    // Descriptor queue depth
    localparam int Q_DEPTH = 2;

    // Phase bits inside a descriptor's non-empty mask
    localparam int PH_N   = 5;
    localparam int PH_CT  = 0;
    localparam int PH_CB  = 1;
    localparam int PH_OP1 = 2;
    localparam int PH_OP2 = 3;
    localparam int PH_FL  = 4;

    typedef logic [ROW_W-1:0] row_t;
    typedef logic [X_W-1:0]   xpos_t;

    // One column's work, as row ranges [lo, hi)
    typedef struct packed {
        xpos_t             x;
        xpos_t             xr;
        row_t              ct_lo;
        row_t              ct_hi;
        row_t              cb_lo;
        row_t              cb_hi;
        row_t              o1_lo;
        row_t              o1_hi;
        row_t              o2_lo;
        row_t              o2_hi;
        row_t              fl_lo;
        row_t              fl_hi;
        logic [PH_N-1:0]   ne;
    } desc_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CT,
        B_CB,
        B_OP1,
        B_OP2,
        B_FL
    } bstate_t;

    function automatic row_t min_row(input row_t a, input row_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic row_t max_row(input row_t a, input row_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== rtl/ctsc_front.sv =====
`timescale 1ns / 1ps

module ctsc_front import ctsc_pkg::*; #(
    parameter int ROWS    = ROWS_DEF,
    parameter int COLUMNS = COLUMNS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  logic [X_W-1:0]   column,
    input  logic [ROW_W-1:0] top_row,
    input  logic [ROW_W-1:0] bottom_row,
    input  logic          first_column,
    input  logic          last_column,
    input  logic          q_full,
    output logic          push,
    output desc_t         desc
);

    localparam row_t ROW_MAX = ROW_W'(ROWS);

    row_t  prev_top_reg, prev_top_next;
    row_t  prev_bottom_reg, prev_bottom_next;
    row_t  t1, b1, stop1, tt, stop2, bb;
    xpos_t xs, xr;
    logic [X_W:0] xinc;

    assign item_stall = q_full;
    assign push       = item_valid && !q_full;

    always_comb
    begin
        t1 = (top_row > ROW_MAX) ? ROW_MAX : top_row;
        b1 = (bottom_row > ROW_MAX) ? ROW_MAX : bottom_row;

        // saturate the column and its right neighbor
        if (32'(column) >= COLUMNS)
            xs = X_W'(COLUMNS - 1);
        else
            xs = column;
        xinc = {1'b0, xs} + 1'b1;
        if (32'(xinc) > COLUMNS - 1)
            xr = X_W'(COLUMNS - 1);
        else
            xr = xinc[X_W-1:0];

        stop1 = min_row(t1, prev_bottom_reg);
        tt    = max_row(prev_top_reg, stop1);
        stop2 = max_row(b1, tt);
        bb    = min_row(prev_bottom_reg, stop2);

        desc.x  = xs;
        desc.xr = xr;
        if (first_column)
        begin
            desc.ct_lo = '0;
            desc.ct_hi = '0;
            desc.cb_lo = '0;
            desc.cb_hi = '0;
            desc.o1_lo = t1;
            desc.o1_hi = b1;
            desc.o2_lo = '0;
            desc.o2_hi = '0;
        end
        else
        begin
            desc.ct_lo = prev_top_reg;
            desc.ct_hi = stop1;
            desc.cb_lo = stop2;
            desc.cb_hi = prev_bottom_reg;
            desc.o1_lo = t1;
            desc.o1_hi = min_row(tt, b1);
            desc.o2_lo = max_row(bb, tt);
            desc.o2_hi = b1;
        end
        desc.fl_lo = t1;
        desc.fl_hi = b1;

        desc.ne[PH_CT]  = desc.ct_lo < desc.ct_hi;
        desc.ne[PH_CB]  = desc.cb_lo < desc.cb_hi;
        desc.ne[PH_OP1] = desc.o1_lo < desc.o1_hi;
        desc.ne[PH_OP2] = desc.o2_lo < desc.o2_hi;
        desc.ne[PH_FL]  = last_column && (t1 < b1);

        prev_top_next    = prev_top_reg;
        prev_bottom_next = prev_bottom_reg;
        if (push)
        begin
            prev_top_next    = last_column ? '0 : t1;
            prev_bottom_next = last_column ? '0 : b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_top_reg    <= '0;
            prev_bottom_reg <= '0;
        end
        else
        begin
            prev_top_reg    <= prev_top_next;
            prev_bottom_reg <= prev_bottom_next;
        end
    end

endmodule

// ===== rtl/ctsc_queue.sv =====
`timescale 1ns / 1ps

module ctsc_queue import ctsc_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_data,
    output logic  full,
    input  logic  pop,
    output desc_t head,
    output logic  empty
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    desc_t             entry_reg [Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full  = (count_reg == CNT_W'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (32'(wr_ptr_reg) == Q_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (32'(rd_ptr_reg) == Q_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && full |-> pop)
        else $error("descriptor pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("descriptor popped from an empty queue");

endmodule

// ===== rtl/ctsc_back.sv =====
`timescale 1ns / 1ps

module ctsc_back import ctsc_pkg::*; #(
    parameter int ROWS = ROWS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  desc_t head,
    input  logic  q_empty,
    output logic  pop,
    output logic  span_valid,
    input  logic  span_stall,
    output logic [OUT_ROW_W-1:0] row,
    output logic [X_W-1:0]       left_x,
    output logic [X_W-1:0]       right_x,
    output logic                 last_span
);

    localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    bstate_t state_reg, state_next;
    desc_t   cmd_reg, cmd_next;
    row_t    cur_reg, cur_next;

    logic                 rd_valid_reg, rd_valid_next;
    logic [OUT_ROW_W-1:0] rd_row_reg, rd_row_next;
    xpos_t                rd_lx_reg, rd_lx_next;
    logic                 rd_last_reg, rd_last_next;
    xpos_t                mem_q_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [OUT_ROW_W-1:0] out_row_reg, out_row_next;
    xpos_t                out_lx_reg, out_lx_next;
    xpos_t                out_rx_reg, out_rx_next;
    logic                 out_last_reg, out_last_next;

    xpos_t span_mem [ROWS];

    logic            move_rd, rd_free, step, done_row, issue, wr_en;
    logic [PH_N-1:0] later;

    function automatic bstate_t pick(input logic [PH_N-1:0] mask);
        if (mask[PH_CT])
            return B_CT;
        else if (mask[PH_CB])
            return B_CB;
        else if (mask[PH_OP1])
            return B_OP1;
        else if (mask[PH_OP2])
            return B_OP2;
        else if (mask[PH_FL])
            return B_FL;
        else
            return B_IDLE;
    endfunction

    function automatic row_t start_cur(input bstate_t st, input desc_t d);
        row_t r;
        unique case (st)
            B_CT:    r = d.ct_lo;
            B_CB:    r = d.cb_hi - 1'b1;
            B_OP1:   r = d.o1_lo;
            B_OP2:   r = d.o2_lo;
            B_FL:    r = d.fl_hi - 1'b1;
            default: r = '0;
        endcase
        return r;
    endfunction

    assign move_rd = rd_valid_reg && (!out_valid_reg || !span_stall);
    assign rd_free = !rd_valid_reg || move_rd;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        cur_next   = cur_reg;
        pop        = 1'b0;
        step       = 1'b0;
        done_row   = 1'b0;
        issue      = 1'b0;
        wr_en      = 1'b0;
        later      = '0;
        rd_last_next = rd_last_reg;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = head;
                    state_next = pick(head.ne);
                    cur_next   = start_cur(state_next, head);
                end
            end
            B_CT:
            begin
                step     = rd_free;
                issue    = rd_free;
                done_row = (cur_reg + 1'b1 == cmd_reg.ct_hi);
                later    = cmd_reg.ne & 5'b11110;
                rd_last_next = done_row && !cmd_reg.ne[PH_CB] && !cmd_reg.ne[PH_FL];
            end
            B_CB:
            begin
                step     = rd_free;
                issue    = rd_free;
                done_row = (cur_reg == cmd_reg.cb_lo);
                later    = cmd_reg.ne & 5'b11100;
                rd_last_next = done_row && !cmd_reg.ne[PH_FL];
            end
            B_OP1:
            begin
                step     = 1'b1;
                wr_en    = 1'b1;
                done_row = (cur_reg + 1'b1 == cmd_reg.o1_hi);
                later    = cmd_reg.ne & 5'b11000;
            end
            B_OP2:
            begin
                step     = 1'b1;
                wr_en    = 1'b1;
                done_row = (cur_reg + 1'b1 == cmd_reg.o2_hi);
                later    = cmd_reg.ne & 5'b10000;
            end
            B_FL:
            begin
                step     = rd_free;
                issue    = rd_free;
                done_row = (cur_reg == cmd_reg.fl_lo);
                later    = '0;
                rd_last_next = done_row;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        // advance the cursor or move on to the next non-empty phase
        if (step)
        begin
            if (done_row)
            begin
                state_next = pick(later);
                cur_next   = start_cur(state_next, cmd_reg);
            end
            else if (state_reg == B_CB || state_reg == B_FL)
                cur_next = cur_reg - 1'b1;
            else
                cur_next = cur_reg + 1'b1;
        end

        // read stage: row and left edge, start column arrives from the memory
        rd_valid_next = rd_valid_reg;
        rd_row_next   = rd_row_reg;
        rd_lx_next    = rd_lx_reg;
        if (issue)
        begin
            rd_valid_next = 1'b1;
            rd_row_next   = cur_reg[OUT_ROW_W-1:0];
            rd_lx_next    = (state_reg == B_FL) ? cmd_reg.x : cmd_reg.xr;
        end
        else
        begin
            if (move_rd)
                rd_valid_next = 1'b0;
            rd_last_next = rd_last_reg;
        end

        // output register
        out_valid_next = out_valid_reg;
        out_row_next   = out_row_reg;
        out_lx_next    = out_lx_reg;
        out_rx_next    = out_rx_reg;
        out_last_next  = out_last_reg;
        if (move_rd)
        begin
            out_valid_next = 1'b1;
            out_row_next   = rd_row_reg;
            out_lx_next    = rd_lx_reg;
            out_rx_next    = mem_q_reg;
            out_last_next  = rd_last_reg;
        end
        else if (out_valid_reg && !span_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        cur_reg      <= cur_next;
        rd_row_reg   <= rd_row_next;
        rd_lx_reg    <= rd_lx_next;
        rd_last_reg  <= rd_last_next;
        out_row_reg  <= out_row_next;
        out_lx_reg   <= out_lx_next;
        out_rx_reg   <= out_rx_next;
        out_last_reg <= out_last_next;
    end

    // span-start store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            span_mem[cur_reg[AW-1:0]] <= cmd_reg.x;
        if (issue)
            mem_q_reg <= span_mem[cur_reg[AW-1:0]];
    end

    assign span_valid = out_valid_reg;
    assign row        = out_row_reg;
    assign left_x     = out_lx_reg;
    assign right_x    = out_rx_reg;
    assign last_span  = out_last_reg;

    a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg && !move_rd |=> rd_valid_reg && $stable(rd_row_reg)
            && $stable(mem_q_reg))
        else $error("read stage overwritten while blocked");

    a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != B_IDLE |-> 32'(cur_reg) < ROWS)
        else $error("row cursor outside the span-start store");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        issue && rd_last_next |=> !issue)
        else $error("read issued right after the final span of a column");

endmodule

// ===== rtl/column_to_span_converter_unit.sv =====
`timescale 1ns / 1ps
// Order: a column beat is written into the descriptor queue, which the back end pops
//   when idle; its first span then leaves through the read stage and the output register,
//   and a column that only flushes first writes the span start of each row it opens.
// Flow: columns wait in the queue while the back end's row cursor walks each row the last
//   one closed, opened or flushed; reads of the span-start store wait on a span stall.
// Reset: rst_n empties queue, pipeline and previous run; the span-start store keeps its data.

module column_to_span_converter_unit import ctsc_pkg::*; #(
    parameter int ROWS    = ROWS_DEF,
    parameter int COLUMNS = COLUMNS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,

    // column channel
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [X_W-1:0]       column,
    input  logic [ROW_W-1:0]     top_row,
    input  logic [ROW_W-1:0]     bottom_row,
    input  logic                 first_column,
    input  logic                 last_column,

    // span channel
    output logic                 span_valid,
    input  logic                 span_stall,
    output logic [OUT_ROW_W-1:0] row,
    output logic [X_W-1:0]       left_x,
    output logic [X_W-1:0]       right_x,
    output logic                 last_span
);

    // Front: hold the previous column's run, clamp the inputs and reduce
    // each column beat to a descriptor of row ranges to close, open and flush.
    // Queue: decouple the front from the back so columns keep flowing while
    // the back end works row by row.
    // Back: walk the ranges one row a cycle, reads waiting out span stalls, write span
    // starts for opening rows, read them for closing rows, emit one span beat per closed row.

    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;
    desc_t push_desc;
    desc_t head_desc;

    ctsc_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .column       (column),
        .top_row      (top_row),
        .bottom_row   (bottom_row),
        .first_column (first_column),
        .last_column  (last_column),
        .q_full       (q_full),
        .push         (push),
        .desc         (push_desc)
    );

    ctsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_desc),
        .full      (q_full),
        .pop       (pop),
        .head      (head_desc),
        .empty     (q_empty)
    );

    ctsc_back #(
        .ROWS (ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_desc),
        .q_empty    (q_empty),
        .pop        (pop),
        .span_valid (span_valid),
        .span_stall (span_stall),
        .row        (row),
        .left_x     (left_x),
        .right_x    (right_x),
        .last_span  (last_span)
    );

endmodule

// ===== tb/sv/column_to_span_converter_unit_test.sv =====
`timescale 1ns / 1ps

// Checks the column to span converter.
//
// A sender process feeds columns, first a fixed list and then random
// regions, and a separate receiver process stalls the span channel.
// Every column that the block takes is run through a local model of the
// span tracker. The model keeps its own run and per-row open-span edges,
// and the spans it closes are queued here. Each span that leaves the
// block is compared with the head of that queue.
module column_to_span_converter_unit_test;
    import ctsc_pkg::*;

    localparam int NUM_ROWS     = ROWS_DEF;
    localparam int NUM_COLS     = COLUMNS_DEF;
    localparam int RANDOM_ITEMS = 210;
    localparam int HOLD_AT      = 80;      // beat count that starts the long receiver hold
    localparam int LONG_HOLD    = 400;     // receiver hold length, in cycles
    localparam int PAUSE_AT     = 150;     // beat count at which the sender waits for a drain
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_SHOWN    = 10;
    localparam int LIMIT_CYCLES = 1000000;

    // Where the expected spans of a listed column come from: the local model,
    // or a value typed into the list (no span at all, or exactly one span).
    typedef enum logic [1:0] {
        SRC_MODEL,
        SRC_NONE,
        SRC_ONE
    } span_src_t;

    typedef struct packed {
        xpos_t                col;
        row_t                 top;
        row_t                 bot;
        logic                 first;
        logic                 last_c;
        span_src_t            src;
        logic [OUT_ROW_W-1:0] e_row;
        xpos_t                e_lx;
        xpos_t                e_rx;
    } column_beat_t;

    typedef struct packed {
        logic [OUT_ROW_W-1:0] row;
        xpos_t                lx;
        xpos_t                rx;
        logic                 fin;
    } span_t;

    localparam int NUM_DIRECTED = 21;

    // Directed columns. Typed rows can be read straight off the rules;
    // the rest go through the local model.
    localparam column_beat_t DIRECTED [NUM_DIRECTED] = '{
        // no first column since reset: the old run is empty, nothing closes
        '{10'd5,    7'd3,   7'd9,   1'b0, 1'b0, SRC_NONE,  6'd0,  10'd0,    10'd0},
        // first and last together on the bottom row, at the rightmost x
        '{10'd1023, 7'd63,  7'd64,  1'b1, 1'b1, SRC_ONE,   6'd63, 10'd1023, 10'd1023},
        // first and last together on the top row, at x zero
        '{10'd0,    7'd0,   7'd1,   1'b1, 1'b1, SRC_ONE,   6'd0,  10'd0,    10'd0},
        // both rows past the screen: they saturate and cover nothing
        '{10'd700,  7'd100, 7'd127, 1'b1, 1'b1, SRC_NONE,  6'd0,  10'd0,    10'd0},
        // empty run opening a region
        '{10'd10,   7'd20,  7'd20,  1'b1, 1'b0, SRC_NONE,  6'd0,  10'd0,    10'd0},
        // full-height region, then shrink from both ends
        '{10'd1000, 7'd0,   7'd64,  1'b1, 1'b0, SRC_MODEL, 6'd0,  10'd0,    10'd0},
        '{10'd999,  7'd5,   7'd60,  1'b0, 1'b0, SRC_MODEL, 6'd0,  10'd0,    10'd0},
        '{10'd998,  7'd10,  7'd50,  1'b0, 1'b0, SRC_MODEL, 6'd0,  10'd0,    10'd0},
        // disjoint run below, bottom saturated
        '{10'd997,  7'd60,  7'd127, 1'b0, 1'b0, SRC_MODEL, 6'd0,  10'd0,    10'd0},
        // inverted run closes everything
        '{10'd996,  7'd30,  7'd20,  1'b0, 1'b0, SRC_MODEL, 6'd0,  10'd0,    10'd0},
        '{10'd995,  7'd2,   7'd40,  1'b0, 1'b0, SRC_MODEL, 6'd0,  10'd0,    10'd0},
        '{10'd994,  7'd0,   7'd40,  1'b0, 1'b1, SRC_MODEL, 6'd0,  10'd0,    10'd0},
        // after a flush the old run is empty again
        '{10'd500,  7'd1,   7'd8,   1'b0, 1'b0, SRC_MODEL, 6'd0,  10'd0,    10'd0},
        '{10'd499,  7'd1,   7'd8,   1'b0, 1'b1, SRC_MODEL, 6'd0,  10'd0,    10'd0},
        // closing at the rightmost x: left edge saturates
        '{10'd1023, 7'd0,   7'd4,   1'b1, 1'b0, SRC_MODEL, 6'd0,  10'd0,    10'd0},
        '{10'd1023, 7'd2,   7'd4,   1'b0, 1'b0, SRC_MODEL, 6'd0,  10'd0,    10'd0},
        '{10'd0,    7'd3,   7'd64,  1'b0, 1'b1, SRC_MODEL, 6'd0,  10'd0,    10'd0},
        '{10'd512,  7'd64,  7'd0,   1'b1, 1'b1, SRC_NONE,  6'd0,  10'd0,    10'd0},
        // largest burst: every row flushed at once
        '{10'd0,    7'd0,   7'd64,  1'b1, 1'b1, SRC_MODEL, 6'd0,  10'd0,    10'd0},
        '{10'd682,  7'd127, 7'd127, 1'b0, 1'b0, SRC_NONE,  6'd0,  10'd0,    10'd0},
        '{10'd341,  7'd85,  7'd42,  1'b1, 1'b0, SRC_NONE,  6'd0,  10'd0,    10'd0}
    };

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_stall;
    logic [X_W-1:0]       column       = '0;
    logic [ROW_W-1:0]     top_row      = '0;
    logic [ROW_W-1:0]     bottom_row   = '0;
    logic                 first_column = 1'b0;
    logic                 last_column  = 1'b0;
    logic                 span_valid;
    logic                 span_stall   = 1'b0;
    logic [OUT_ROW_W-1:0] row;
    logic [X_W-1:0]       left_x;
    logic [X_W-1:0]       right_x;
    logic                 last_span;

    // Model state: right edge of the open span per row, and the last run.
    xpos_t open_right [NUM_ROWS];
    int    prev_lo;
    int    prev_hi;

    span_t spans_due [$];   // spans still owed by the block, oldest first
    span_t column_spans [$]; // spans closed by the column being modeled

    int  mismatches  = 0;
    int  cycle_count = 0;
    int  beats_fed   = 0;
    int  spans_seen  = 0;
    int  rx_wait     = 0;
    int  long_hold   = 0;
    bit  tx_calm     = 1'b0;
    bit  rx_calm     = 1'b0;

    column_to_span_converter_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .column       (column),
        .top_row      (top_row),
        .bottom_row   (bottom_row),
        .first_column (first_column),
        .last_column  (last_column),
        .span_valid   (span_valid),
        .span_stall   (span_stall),
        .row          (row),
        .left_x       (left_x),
        .right_x      (right_x),
        .last_span    (last_span)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Wait length for one beat: zero during a calm stretch, else drawn at random from 0 to 8.
    function automatic int pause_len(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 8));
    endfunction

    // Saturate a row index at the screen height.
    function automatic int clip_row(input row_t r);
        return (int'(r) > NUM_ROWS) ? NUM_ROWS : int'(r);
    endfunction

    function automatic void close_span(input int y, input xpos_t lx);
        column_spans.push_back('{row: y[OUT_ROW_W-1:0], lx: lx, rx: open_right[y], fin: 1'b0});
    endfunction

    // Advance the span tracker by one column and collect the spans it closes.
    function automatic void trace_spans(input column_beat_t b);
        int    t1;
        int    b1;
        int    t2;
        int    b2;
        int    lim;
        int    y;
        xpos_t x;
        xpos_t xr;
        column_spans.delete();
        x  = (int'(b.col) >= NUM_COLS) ? xpos_t'(NUM_COLS - 1) : b.col;
        t1 = clip_row(b.top);
        b1 = clip_row(b.bot);
        if (b.first)
        begin
            for (y = t1; y < b1; y++)
                open_right[y] = x;
            t2 = t1;
            b2 = b1;
        end
        else
        begin
            xr = (int'(x) + 1 > NUM_COLS - 1) ? xpos_t'(NUM_COLS - 1) : x + 1'b1;
            t2 = prev_lo;
            b2 = prev_hi;
            // close at the top, rising, then at the bottom, falling
            lim = (t1 < b2) ? t1 : b2;
            while (t2 < lim)
            begin
                close_span(t2, xr);
                t2++;
            end
            lim = (b1 > t2) ? b1 : t2;
            while (b2 > lim)
            begin
                b2--;
                close_span(b2, xr);
            end
            // open the new rows on both ends
            lim = (t2 < b1) ? t2 : b1;
            for (y = t1; y < lim; y++)
                open_right[y] = x;
            lim = (b2 > t2) ? b2 : t2;
            for (y = b1 - 1; y >= lim; y--)
                open_right[y] = x;
            t2 = t1;
            b2 = b1;
        end
        if (b.last_c)
        begin
            while (t2 < b2)
            begin
                b2--;
                close_span(b2, x);
            end
            t2 = 0;
            b2 = 0;
        end
        prev_lo = t2;
        prev_hi = b2;
        if (column_spans.size() > 0)
            column_spans[column_spans.size() - 1].fin = 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input span_t want, input span_t got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("mismatch (%s) at cycle %0d: want row %0d lx %0d rx %0d last %0b, got row %0d lx %0d rx %0d last %0b",
                     what, cycle_count, want.row, want.lx, want.rx, want.fin,
                     got.row, got.lx, got.rx, got.fin);
    endtask

    // Drop valid at the next falling edge, then wait for every owed span.
    task automatic wait_drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (spans_due.size() != 0)
            @(posedge clk);
    endtask

    // Offer one column beat, hold it until taken, then queue what it owes.
    task automatic feed(input column_beat_t b);
        int gap;
        gap = pause_len(tx_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            // drop valid and scramble the idle payload
            item_valid   <= 1'b0;
            column       <= xpos_t'($urandom);
            top_row      <= row_t'($urandom);
            bottom_row   <= row_t'($urandom);
            first_column <= 1'(($urandom));
            last_column  <= 1'(($urandom));
            repeat (gap) @(negedge clk);
        end
        item_valid   <= 1'b1;
        column       <= b.col;
        top_row      <= b.top;
        bottom_row   <= b.bot;
        first_column <= b.first;
        last_column  <= b.last_c;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);

        trace_spans(b);
        case (b.src)
            SRC_NONE: column_spans.delete();
            SRC_ONE:  column_spans = '{'{row: b.e_row, lx: b.e_lx, rx: b.e_rx, fin: 1'b1}};
            default:  ;
        endcase
        foreach (column_spans[i])
            spans_due.push_back(column_spans[i]);

        beats_fed++;
        if (beats_fed % 40 == 0)
            tx_calm = ($urandom_range(0, 2) == 0);
        // start the long receiver hold from a rising edge; the receiver counts it down
        if (beats_fed == HOLD_AT)
            long_hold = LONG_HOLD;
        if (beats_fed == PAUSE_AT)
            wait_drain();
    endtask

    // Receiver: hold off for the long stretch, then for the drawn wait, else take.
    always @(negedge clk)
    begin
        if (long_hold > 0)
        begin
            long_hold--;
            span_stall <= 1'b1;
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            span_stall <= 1'b1;
        end
        else
            span_stall <= 1'b0;
    end

    // Compare each accepted span with the oldest one owed.
    always @(posedge clk)
    begin
        span_t got;
        span_t want;
        if (rst_n && span_valid && !span_stall)
        begin
            got = '{row: row, lx: left_x, rx: right_x, fin: last_span};
            if (spans_due.size() == 0)
                flag_mismatch("unexpected span", '0, got);
            else
            begin
                want = spans_due.pop_front();
                if (got !== want)
                    flag_mismatch("wrong span", want, got);
            end
            spans_seen++;
            if (spans_seen % 50 == 0)
                rx_calm = ($urandom_range(0, 2) == 0);
            rx_wait = pause_len(rx_calm);
        end
    end

    initial
    begin
        column_beat_t b;
        int           rand_items;
        int           n_cols;
        int           x_i;
        int           top_i;
        int           bot_i;
        bit           tall;

        foreach (open_right[i])
            open_right[i] = '0;
        prev_lo    = 0;
        prev_hi    = 0;
        rand_items = 0;

        // Hold reset once, then release it on a falling edge.
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed list.
        for (int i = 0; i < NUM_DIRECTED; i++)
            feed(DIRECTED[i]);
        // Pause the sender until every span owed so far has arrived.
        wait_drain();

        // Random part: mostly well-formed regions with random content,
        // some noise beats and some regions that never get flushed.
        while (rand_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                b = '{col: xpos_t'($urandom), top: row_t'($urandom), bot: row_t'($urandom),
                      first: 1'($urandom), last_c: 1'($urandom), src: SRC_MODEL,
                      e_row: '0, e_lx: '0, e_rx: '0};
                feed(b);
                rand_items++;
            end
            else
            begin
                n_cols = $urandom_range(1, 12);
                x_i    = ($urandom_range(0, 7) == 0) ? NUM_COLS - 1
                                                     : int'($urandom_range(0, NUM_COLS - 1));
                tall   = ($urandom_range(0, 7) == 0);
                top_i  = tall ? int'($urandom_range(0, 6)) : int'($urandom_range(0, 60));
                bot_i  = top_i + (tall ? int'($urandom_range(40, 64)) : int'($urandom_range(1, 8)));
                if (bot_i > NUM_ROWS)
                    bot_i = NUM_ROWS;
                for (int k = 0; k < n_cols && rand_items < RANDOM_ITEMS; k++)
                begin
                    b.col    = xpos_t'(x_i);
                    b.top    = ($urandom_range(0, 24) == 0) ? row_t'($urandom_range(65, 127))
                                                            : row_t'(top_i);
                    b.bot    = ($urandom_range(0, 19) == 0) ? row_t'($urandom_range(65, 127))
                                                            : row_t'(bot_i);
                    b.first  = (k == 0);
                    // leave some regions open to break the sequence
                    b.last_c = (k == n_cols - 1) && ($urandom_range(0, 9) != 0);
                    b.src    = SRC_MODEL;
                    b.e_row  = '0;
                    b.e_lx   = '0;
                    b.e_rx   = '0;
                    feed(b);
                    rand_items++;

                    // advance leftward and let the run drift
                    x_i = x_i - int'($urandom_range(0, 3));
                    if (x_i < 0)
                        x_i = 0;
                    if ($urandom_range(0, 7) == 0)
                    begin
                        top_i = $urandom_range(0, NUM_ROWS);
                        bot_i = $urandom_range(0, NUM_ROWS);
                    end
                    else
                    begin
                        top_i = top_i + int'($urandom_range(0, 6)) - 3;
                        bot_i = bot_i + int'($urandom_range(0, 6)) - 3;
                    end
                    top_i = (top_i < 0) ? 0 : ((top_i > NUM_ROWS) ? NUM_ROWS : top_i);
                    bot_i = (bot_i < 0) ? 0 : ((bot_i > NUM_ROWS) ? NUM_ROWS : bot_i);
                end
            end
        end

        @(negedge clk);
        item_valid <= 1'b0;

        // Drain, then watch a while longer for stray spans.
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && spans_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ctsc_pkg.sv
rtl/ctsc_front.sv
rtl/ctsc_queue.sv
rtl/ctsc_back.sv
rtl/column_to_span_converter_unit.sv
tb/sv/column_to_span_converter_unit_test.sv
